[rtl/core/hnp_pkg.sv]
package hnp_pkg;

    localparam int ID_BITS_DEF      = 24;
    localparam int CORDIC_STEPS_DEF = 24;

    localparam int LAT_W  = 30;
    localparam int LON_W  = 31;
    localparam int DIST_W = 25;
    localparam int Q_W    = 31;
    localparam int CW     = 34;
    localparam int SQ_W   = 62;
    localparam int RAD_W  = 61;
    localparam int SQRT_STEPS = 31;

    localparam logic [31:0] DEG_RAD        = 32'd74961321;
    localparam logic [31:0] DIAM_Q10       = 32'd13040538;
    localparam logic [31:0] HALF_TURN_H    = 32'd1509949440;
    localparam logic [31:0] QUARTER_TURN_H = 32'd754974720;
    localparam logic [31:0] HALF_TURN_L    = 32'd754974720;
    localparam logic [31:0] QUARTER_TURN_L = 32'd377487360;
    localparam logic signed [CW-1:0] INV_GAIN = 34'sd652032874;
    localparam logic [Q_W-1:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [DIST_W-1:0] DIST_MAX  = 25'd20484096;
    localparam logic [DIST_W-1:0] DIST_ONES = '1;

    typedef enum logic [4:0] {
        S_IDLE, S_ANG1, S_ANG2, S_ANG3, S_AMUL, S_ARAD, S_ACORD,
        S_MSET, S_MWAIT, S_MGET, S_HAV, S_SQV, S_SQW, S_VEC,
        S_DWAIT, S_DIST, S_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic rot_mode;
    } t_cordic_req;

    function automatic logic [30:0] atan_q30(input logic [4:0] idx);
        logic [30:0] v;
        case (idx)
            5'd0:  v = 31'd843314856;
            5'd1:  v = 31'd497837829;
            5'd2:  v = 31'd263043836;
            5'd3:  v = 31'd133525158;
            5'd4:  v = 31'd67021686;
            5'd5:  v = 31'd33543515;
            5'd6:  v = 31'd16775850;
            5'd7:  v = 31'd8388437;
            5'd8:  v = 31'd4194282;
            5'd9:  v = 31'd2097149;
            5'd10: v = 31'd1048575;
            5'd11: v = 31'd524287;
            5'd12: v = 31'd262143;
            5'd13: v = 31'd131071;
            5'd14: v = 31'd65535;
            5'd15: v = 31'd32767;
            5'd16: v = 31'd16383;
            5'd17: v = 31'd8191;
            5'd18: v = 31'd4095;
            5'd19: v = 31'd2047;
            5'd20: v = 31'd1023;
            5'd21: v = 31'd511;
            5'd22: v = 31'd255;
            5'd23: v = 31'd127;
            5'd24: v = 31'd63;
            5'd25: v = 31'd31;
            5'd26: v = 31'd15;
            5'd27: v = 31'd8;
            5'd28: v = 31'd4;
            5'd29: v = 31'd2;
            5'd30: v = 31'd1;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

    function automatic logic [Q_W-1:0] clamp_q30(input logic signed [CW-1:0] v);
        logic [Q_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed(CW'(ONE_Q30))) begin
            r = ONE_Q30;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/hnp_cordic.sv]
module hnp_cordic #(
    parameter int CORDIC_STEPS = hnp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hnp_pkg::t_cordic_req           i_req,
    input  logic signed [hnp_pkg::CW-1:0]  i_x,
    input  logic signed [hnp_pkg::CW-1:0]  i_y,
    input  logic signed [hnp_pkg::CW-1:0]  i_z,
    output logic                           o_done,
    output logic signed [hnp_pkg::CW-1:0]  o_x,
    output logic signed [hnp_pkg::CW-1:0]  o_y,
    output logic signed [hnp_pkg::CW-1:0]  o_z
);
    import hnp_pkg::*;

    localparam int IW = $clog2(CORDIC_STEPS);

    logic              r_busy, r_done, r_rot;
    logic [IW-1:0]     r_i;
    logic signed [CW-1:0] r_x, r_y, r_z;
    logic signed [CW-1:0] n_x, n_y, n_z;
    logic signed [CW-1:0] w_xs, w_ys, w_at;
    logic              w_pos;

    always_comb begin
        w_xs  = r_x >>> r_i;
        w_ys  = r_y >>> r_i;
        w_at  = CW'(atan_q30(5'(r_i)));
        // rotation mode steers by the angle, vectoring mode drives y to zero
        w_pos = r_rot ? !r_z[CW-1] : r_y[CW-1];
        if (w_pos) begin
            n_x = r_x - w_ys;
            n_y = r_y + w_xs;
            n_z = r_z - w_at;
        end else begin
            n_x = r_x + w_ys;
            n_y = r_y - w_xs;
            n_z = r_z + w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rot  <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rot  <= i_req.rot_mode;
                r_i    <= '0;
            end else if (r_busy) begin
                if (r_i == IW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= i_z;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

[rtl/core/hnp_sqrt.sv]
module hnp_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hnp_pkg::RAD_W-1:0]   i_rad,
    output logic                        o_done,
    output logic [hnp_pkg::Q_W-1:0]     o_root
);
    import hnp_pkg::*;

    logic             r_busy, r_done;
    logic [4:0]       r_k;
    logic [SQ_W-1:0]  r_n, r_r;
    logic [SQ_W-1:0]  n_n, n_r, w_b, w_sum;

    // restoring square root, one result bit per cycle
    always_comb begin
        w_b   = SQ_W'(1) << {r_k, 1'b0};
        w_sum = r_r + w_b;
        if (r_n >= w_sum) begin
            n_n = r_n - w_sum;
            n_r = (r_r >> 1) + w_b;
        end else begin
            n_n = r_n;
            n_r = r_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= 5'(SQRT_STEPS - 1);
            end else if (r_busy) begin
                if (r_k == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k <= r_k - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n <= SQ_W'(i_rad);
            r_r <= '0;
        end else if (r_busy) begin
            r_n <= n_n;
            r_r <= n_r;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[Q_W-1:0];

endmodule

[rtl/core/haversine_nearest_point.sv]
// Nearest candidate to a query point by haversine great-circle distance.
// Input channel (i_valid / o_ready): one request per candidate, carrying the
// query point, the candidate point and id, and the cand_valid, first_item and
// last_item flags. first_item clears the running minimum before the candidate
// is weighed; only a strictly smaller distance replaces the best.
// Output channel (o_valid / i_ready): one result on each request marked
// last_item: found, best id and best distance in 1/1024 km (zero if none).
// A request with a candidate takes four sine/cosine runs and one arctangent
// run of the shared CORDIC, two 31-step square roots, and nine passes
// through the one 32x32 multiplier. A request with no candidate goes
// straight from idle to the emit state.
// o_ready is high only while the sequencer is idle. The result sits in an
// output register, so the next request is taken while it waits; if the
// receiver still stalls when the next result is due, the sequencer holds.
// Reset (synchronous, active low) empties the result register and clears the
// running minimum.
module haversine_nearest_point #(
    parameter int ID_BITS      = hnp_pkg::ID_BITS_DEF,
    parameter int CORDIC_STEPS = hnp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [hnp_pkg::LAT_W-1:0]  i_query_lat,
    input  logic signed [hnp_pkg::LON_W-1:0]  i_query_lon,
    input  logic signed [hnp_pkg::LAT_W-1:0]  i_cand_lat,
    input  logic signed [hnp_pkg::LON_W-1:0]  i_cand_lon,
    input  logic [ID_BITS-1:0]                i_cand_id,
    input  logic                              i_cand_valid,
    input  logic                              i_first_item,
    input  logic                              i_last_item,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_found,
    output logic [ID_BITS-1:0]                o_best_id,
    output logic [hnp_pkg::DIST_W-1:0]        o_best_distance
);
    import hnp_pkg::*;

    t_state r_state, n_state;

    logic signed [LAT_W-1:0] r_qlat, r_clat;
    logic signed [LON_W-1:0] r_qlon, r_clon;
    logic [ID_BITS-1:0]      r_id;
    logic                    r_last;

    logic [1:0]      r_k, n_k, r_mi, n_mi;
    logic [31:0]     r_a, n_a, r_ma, n_ma, r_mb, n_mb;
    logic            r_n1, n_n1, r_n2, n_n2;
    logic [Q_W-1:0]  r_s1, n_s1, r_s2, n_s2, r_c1, n_c1, r_c2, n_c2;
    logic [Q_W-1:0]  r_ha, n_ha, r_hb, n_hb, r_h, n_h, r_v, n_v;
    logic [63:0]     r_prod;

    logic [DIST_W-1:0]  r_min, n_min;
    logic [ID_BITS-1:0] r_nid, n_nid;
    logic               r_have, n_have;

    logic               r_ovalid, n_ovalid;
    logic               n_found;
    logic [ID_BITS-1:0] n_bid;
    logic [DIST_W-1:0]  n_bdist;

    logic               w_accept, w_emit_ok;
    logic signed [32:0] w_diff;
    logic [31:0]        w_mag, w_amod, w_fold;
    logic               w_fneg;
    logic [63:0]        w_rad, w_dr;
    logic [Q_W-1:0]     w_q, w_h;
    logic signed [32:0] w_hs;
    logic [DIST_W-1:0]  w_dist;

    t_cordic_req           cd_req;
    logic signed [CW-1:0]  cd_x, cd_y, cd_z, cd_ox, cd_oy, cd_oz;
    logic                  cd_done;
    logic                  sq_start, sq_done;
    logic [RAD_W-1:0]      sq_rad;
    logic [Q_W-1:0]        sq_root;

    hnp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(cd_req),
        .i_x(cd_x), .i_y(cd_y), .i_z(cd_z),
        .o_done(cd_done), .o_x(cd_ox), .o_y(cd_oy), .o_z(cd_oz)
    );

    hnp_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start), .i_rad(sq_rad),
        .o_done(sq_done), .o_root(sq_root)
    );

    assign w_accept  = i_valid && o_ready;
    assign w_emit_ok = !r_ovalid || i_ready;

    // angle reduction: half differences for k 0/1, latitudes for k 2/3
    always_comb begin
        case (r_k)
            2'd0:    w_diff = 33'(r_clat) - 33'(r_qlat);
            2'd1:    w_diff = 33'(r_clon) - 33'(r_qlon);
            2'd2:    w_diff = 33'(r_qlat);
            default: w_diff = 33'(r_clat);
        endcase
        w_mag  = w_diff[32] ? 32'(-w_diff) : 32'(w_diff);
        w_amod = (!r_k[1] && r_a >= HALF_TURN_H) ? r_a - HALF_TURN_H : r_a;
        w_fneg = 1'b0;
        if (!r_k[1]) begin
            w_fold = (r_a > QUARTER_TURN_H) ? HALF_TURN_H - r_a : r_a;
        end else if (r_a > QUARTER_TURN_L) begin
            w_fold = HALF_TURN_L - r_a;
            w_fneg = 1'b1;
        end else begin
            w_fold = r_a;
        end
        w_rad = r_k[1] ? (r_prod + (64'd1 << 23)) >> 24
                       : (r_prod + (64'd1 << 24)) >> 25;
        w_q   = r_prod[60:30];
        w_hs  = (r_n1 ^ r_n2) ? 33'(r_ha) - 33'(r_hb) : 33'(r_ha) + 33'(r_hb);
        if (w_hs < 0) begin
            w_h = '0;
        end else if (w_hs > $signed(33'(ONE_Q30))) begin
            w_h = ONE_Q30;
        end else begin
            w_h = w_hs[Q_W-1:0];
        end
        w_dr   = (r_prod + (64'd1 << 29)) >> 30;
        w_dist = (w_dr > 64'(DIST_MAX)) ? DIST_MAX : w_dr[DIST_W-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = i_cand_valid ? S_ANG1 : S_EMIT;
            S_ANG1:  n_state = S_ANG2;
            S_ANG2:  n_state = S_ANG3;
            S_ANG3:  n_state = S_AMUL;
            S_AMUL:  n_state = S_ARAD;
            S_ARAD:  n_state = S_ACORD;
            S_ACORD: if (cd_done) n_state = (r_k == 2'd3) ? S_MSET : S_ANG1;
            S_MSET:  n_state = S_MWAIT;
            S_MWAIT: n_state = S_MGET;
            S_MGET:  n_state = (r_mi == 2'd3) ? S_HAV : S_MSET;
            S_HAV:   n_state = S_SQV;
            S_SQV:   if (sq_done) n_state = S_SQW;
            S_SQW:   if (sq_done) n_state = S_VEC;
            S_VEC:   if (cd_done) n_state = S_DWAIT;
            S_DWAIT: n_state = S_DIST;
            S_DIST:  n_state = S_EMIT;
            S_EMIT:  if (!r_last || w_emit_ok) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs to the port and the shared units
    always_comb begin
        o_ready         = (r_state == S_IDLE);
        cd_req.start    = 1'b0;
        cd_req.rot_mode = 1'b1;
        cd_x            = INV_GAIN;
        cd_y            = '0;
        cd_z            = $signed(w_rad[CW-1:0]);
        sq_start        = 1'b0;
        sq_rad          = {w_h, 30'd0};
        case (r_state)
            S_ARAD: cd_req.start = 1'b1;
            S_HAV:  sq_start = 1'b1;
            S_SQV: begin
                sq_start = sq_done;
                sq_rad   = {ONE_Q30 - r_h, 30'd0};
            end
            S_SQW: begin
                cd_req.start    = sq_done;
                cd_req.rot_mode = 1'b0;
                cd_x            = CW'(sq_root);
                cd_y            = CW'(r_v);
                cd_z            = '0;
            end
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        n_k = r_k;   n_mi = r_mi;  n_a = r_a;   n_ma = r_ma;  n_mb = r_mb;
        n_n1 = r_n1; n_n2 = r_n2;
        n_s1 = r_s1; n_s2 = r_s2;  n_c1 = r_c1; n_c2 = r_c2;
        n_ha = r_ha; n_hb = r_hb;  n_h = r_h;   n_v = r_v;
        n_min = r_min; n_nid = r_nid; n_have = r_have;
        n_ovalid = r_ovalid && !i_ready;
        n_found = o_found; n_bid = o_best_id; n_bdist = o_best_distance;
        case (r_state)
            S_IDLE: begin
                n_k  = '0;
                n_mi = '0;
                if (w_accept && i_first_item) begin
                    n_min  = DIST_ONES;
                    n_nid  = '0;
                    n_have = 1'b0;
                end
            end
            S_ANG1: n_a = w_mag;
            S_ANG2: n_a = w_amod;
            S_ANG3: begin
                n_ma = w_fold;
                n_mb = DEG_RAD;
                if (r_k == 2'd2) n_n1 = w_fneg;
                if (r_k == 2'd3) n_n2 = w_fneg;
            end
            S_ACORD: if (cd_done) begin
                case (r_k)
                    2'd0:    n_s1 = clamp_q30(cd_oy);
                    2'd1:    n_s2 = clamp_q30(cd_oy);
                    2'd2:    n_c1 = clamp_q30(cd_ox);
                    default: n_c2 = clamp_q30(cd_ox);
                endcase
                n_k = r_k + 1'b1;
            end
            S_MSET: begin
                case (r_mi)
                    2'd0:    begin n_ma = 32'(r_s1); n_mb = 32'(r_s1); end
                    2'd1:    begin n_ma = 32'(r_s2); n_mb = 32'(r_s2); end
                    2'd2:    begin n_ma = 32'(r_hb); n_mb = 32'(r_c1); end
                    default: begin n_ma = 32'(r_hb); n_mb = 32'(r_c2); end
                endcase
            end
            S_MGET: begin
                if (r_mi == 2'd0) begin
                    n_ha = w_q;
                end else begin
                    n_hb = w_q;
                end
                n_mi = r_mi + 1'b1;
            end
            S_HAV: n_h = w_h;
            S_SQV: if (sq_done) n_v = sq_root;
            S_VEC: if (cd_done) begin
                n_ma = cd_oz[CW-1] ? 32'd0 : 32'(cd_oz[30:0]);
                n_mb = DIAM_Q10;
            end
            S_DIST: begin
                if (!r_have || w_dist < r_min) begin
                    n_min  = w_dist;
                    n_nid  = r_id;
                    n_have = 1'b1;
                end
            end
            S_EMIT: if (r_last && w_emit_ok) begin
                n_ovalid = 1'b1;
                n_found  = r_have;
                n_bid    = r_have ? r_nid : '0;
                n_bdist  = r_have ? r_min : '0;
                n_min    = DIST_ONES;
                n_nid    = '0;
                n_have   = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_min    <= DIST_ONES;
            r_nid    <= '0;
            r_have   <= 1'b0;
            r_ovalid <= 1'b0;
            r_k      <= '0;
            r_mi     <= '0;
        end else begin
            r_state  <= n_state;
            r_min    <= n_min;
            r_nid    <= n_nid;
            r_have   <= n_have;
            r_ovalid <= n_ovalid;
            r_k      <= n_k;
            r_mi     <= n_mi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_qlat <= i_query_lat;
            r_qlon <= i_query_lon;
            r_clat <= i_cand_lat;
            r_clon <= i_cand_lon;
            r_id   <= i_cand_id;
            r_last <= i_last_item;
        end
        r_a  <= n_a;   r_ma <= n_ma;  r_mb <= n_mb;
        r_n1 <= n_n1;  r_n2 <= n_n2;
        r_s1 <= n_s1;  r_s2 <= n_s2;  r_c1 <= n_c1;  r_c2 <= n_c2;
        r_ha <= n_ha;  r_hb <= n_hb;  r_h  <= n_h;   r_v  <= n_v;
        r_prod <= r_ma * r_mb;
        o_found         <= n_found;
        o_best_id       <= n_bid;
        o_best_distance <= n_bdist;
    end

    assign o_valid = r_ovalid;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("sequencer took a request and stayed ready");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_best_distance <= DIST_MAX)
        else $error("result distance above saturation");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_best_id == '0 && o_best_distance == '0))
        else $error("empty query result not zero");

    a_min_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> (r_min == DIST_ONES && r_nid == '0))
        else $error("running minimum dirty without a candidate");

endmodule
